// ===== hdl/voxel_cube_frame_buffer_assert.svh =====
// assertion macros shared by the voxel cube frame buffer rtl
`ifndef VOXEL_CUBE_FRAME_BUFFER_ASSERT_SVH
`define VOXEL_CUBE_FRAME_BUFFER_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent in the same cycle implies consequent
`define VCFB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("voxel cube frame buffer check failed");
// antecedent implies consequent in the next cycle
`define VCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("voxel cube frame buffer check failed");
`else
`define VCFB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define VCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/vcfb_pkg.sv =====
// types and constants of the voxel cube frame buffer
package vcfb_pkg;

	localparam int AXIS_SIZE    = 4;
	localparam int COORD_W      = 2;
	localparam int LAYER_W      = AXIS_SIZE * AXIS_SIZE;
	localparam int BIT_W        = 4;
	localparam int BYTE_W       = 8;
	localparam int SELECT_SHIFT = 4;
	localparam int NUM_W        = 6;
	localparam int DEN_W        = 3;
	localparam int QUO_W        = 2;

	typedef enum logic [2:0] {
		OP_SET_XYZ   = 3'd0,
		OP_SET_INDEX = 3'd1,
		OP_FILL_LAYR = 3'd2,
		OP_FILL_ALL  = 3'd3,
		OP_DRAW_LINE = 3'd4,
		OP_READ_LAYR = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	typedef enum logic [1:0] {
		RD_LOW  = 2'd0,
		RD_HIGH = 2'd1,
		RD_SEL  = 2'd2
	} rd_byte_t;

	typedef enum logic [1:0] {
		WR_BIT   = 2'd0,
		WR_LAYER = 2'd1,
		WR_ALL   = 2'd2
	} wr_mode_t;

	typedef enum logic [5:0] {
		ST_IDLE       = 6'b000001,
		ST_LINE_SETUP = 6'b000010,
		ST_LINE_NUM   = 6'b000100,
		ST_LINE_DIV   = 6'b001000,
		ST_LINE_WR    = 6'b010000,
		ST_RD         = 6'b100000
	} state_t;

	typedef struct packed {
		logic             en;
		wr_mode_t         mode;
		logic [1:0]       layer;
		logic [BIT_W-1:0] bit_idx;
		logic             val;
	} store_wr_t;

endpackage

// ===== hdl/vcfb_div.sv =====
// two-step restoring divider for the line interpolation
module vcfb_div import vcfb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	logic             busy_q;
	logic             step_q;
	logic             done_q;
	logic [NUM_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [NUM_W-1:0] cmp;
	logic             ge;

	// first step tries twice the divisor, second the divisor itself
	always_comb begin
		if (step_q) begin
			cmp = NUM_W'(den_q);
		end else begin
			cmp = NUM_W'({den_q, 1'b0});
		end
		ge = (rem_q >= cmp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && step_q;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 1'b0;
			end else if (busy_q) begin
				step_q <= 1'b1;
				if (step_q) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[0], ge};
			if (ge) begin
				rem_q <= rem_q - cmp;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== hdl/vcfb_store.sv =====
// voxel store: one 16-bit word per layer, cleared at reset
module vcfb_store import vcfb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  store_wr_t          wr,
	input  logic [1:0]         rd_layer,
	output logic [LAYER_W-1:0] rd_word
);

	logic [LAYER_W-1:0] layers_q [AXIS_SIZE];
	logic [LAYER_W-1:0] bit_mask;

	assign bit_mask = LAYER_W'(1) << wr.bit_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXIS_SIZE; i++) begin
				layers_q[i] <= '0;
			end
		end else if (wr.en) begin
			case (wr.mode)
				WR_BIT: begin
					if (wr.val) begin
						layers_q[wr.layer] <= layers_q[wr.layer] | bit_mask;
					end else begin
						layers_q[wr.layer] <= layers_q[wr.layer] & ~bit_mask;
					end
				end
				WR_LAYER: begin
					layers_q[wr.layer] <= {LAYER_W{wr.val}};
				end
				WR_ALL: begin
					for (int i = 0; i < AXIS_SIZE; i++) begin
						layers_q[i] <= {LAYER_W{wr.val}};
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rd_word = layers_q[rd_layer];

endmodule

// ===== hdl/voxel_cube_frame_buffer.sv =====
// top level: command sequencer, line engine and readout of the voxel cube
//
// commands enter on the in_valid / in_ready channel, one beat per command;
// readout bytes leave on the out_valid / out_ready channel
// set, set by index, fill layer and fill all update the store at the
// accepting edge; in_ready stays high, so one such command per cycle
// draw line: a setup state, then per point two interpolations on the
// shared divider (each a numerator state and a divide state) and a write
// state; in_ready stays low from acceptance until the last point is written
// read layer: the layer word is sampled at acceptance, then three beats
// follow (low byte, high byte, select byte with last_byte set); each is
// loaded into the output register once that register is free, and in_ready
// returns once the third is loaded
// a stalled receiver holds the output register and the readout waits on it;
// the store is never written during readout
// reset clears the cube to dark and leaves both channels idle
module voxel_cube_frame_buffer import vcfb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic               pixel_value,
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] start_z,
	input  logic [COORD_W-1:0] end_x,
	input  logic [COORD_W-1:0] end_y,
	input  logic [COORD_W-1:0] end_z,
	input  logic [BIT_W-1:0]   bit_index,
	input  logic [1:0]         layer_sel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               last_byte
);

	`include "voxel_cube_frame_buffer_assert.svh"

	state_t state_q;
	logic   in_acc;
	op_t    op;

	// captured line endpoints and value
	logic [COORD_W-1:0] x0_q, y0_q, z0_q, x1_q, y1_q, z1_q;
	logic               val_q;

	// line setup results: dominant start, the two other axes as (a, b)
	axis_t              axis_q;
	logic [COORD_W-1:0] span_q, t_q, dom_q;
	logic [COORD_W-1:0] as_q, ae_q, bs_q, be_q;
	logic [COORD_W-1:0] ca_q, cb_q;
	logic               k_q;

	// readout
	logic [LAYER_W-1:0] rd_word_q;
	logic [1:0]         rd_layer_q;
	rd_byte_t           rd_cnt_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               last_q;
	logic               out_load;
	logic [BYTE_W-1:0]  next_byte;

	// store and divider hookup
	store_wr_t          wr;
	logic [LAYER_W-1:0] rd_word;
	logic               div_start, div_busy, div_done;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic [QUO_W-1:0]   div_quo;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign op       = op_t'(opcode);

	// ------------------------------------------------------------------
	// line setup: distances, dominant axis (ties to z), endpoint swap
	// ------------------------------------------------------------------
	logic [COORD_W-1:0] dx, dy, dz;
	axis_t              su_axis;
	logic               su_swap;
	logic [COORD_W-1:0] spx, spy, spz, sqx, sqy, sqz;
	logic [COORD_W-1:0] su_span, su_dom, su_as, su_ae, su_bs, su_be;

	always_comb begin
		dx = (x0_q > x1_q) ? x0_q - x1_q : x1_q - x0_q;
		dy = (y0_q > y1_q) ? y0_q - y1_q : y1_q - y0_q;
		dz = (z0_q > z1_q) ? z0_q - z1_q : z1_q - z0_q;
		if (dx > dy && dx > dz) begin
			su_axis = AX_X;
			su_swap = (x0_q > x1_q);
		end else if (dy > dx && dy > dz) begin
			su_axis = AX_Y;
			su_swap = (y0_q > y1_q);
		end else begin
			su_axis = AX_Z;
			su_swap = (z0_q > z1_q);
		end
		spx = su_swap ? x1_q : x0_q;
		spy = su_swap ? y1_q : y0_q;
		spz = su_swap ? z1_q : z0_q;
		sqx = su_swap ? x0_q : x1_q;
		sqy = su_swap ? y0_q : y1_q;
		sqz = su_swap ? z0_q : z1_q;
		case (su_axis)
			AX_X: begin
				su_span = dx;
				su_dom  = spx;
				su_as   = spy;
				su_ae   = sqy;
				su_bs   = spz;
				su_be   = sqz;
			end
			AX_Y: begin
				su_span = dy;
				su_dom  = spy;
				su_as   = spx;
				su_ae   = sqx;
				su_bs   = spz;
				su_be   = sqz;
			end
			default: begin
				su_span = dz;
				su_dom  = spz;
				su_as   = spx;
				su_ae   = sqx;
				su_bs   = spy;
				su_be   = sqy;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// interpolation numerator 2*s*span + 2*(e-s)*t + span over 2*span
	// ------------------------------------------------------------------
	logic [COORD_W-1:0] ip_s, ip_e;
	logic [3:0]         s_span;
	logic signed [3:0]  dlt;
	logic signed [6:0]  dlt_t;
	logic signed [6:0]  num_s;

	always_comb begin
		ip_s   = k_q ? bs_q : as_q;
		ip_e   = k_q ? be_q : ae_q;
		s_span = 4'(ip_s) * 4'(span_q);
		dlt    = signed'({2'b00, ip_e}) - signed'({2'b00, ip_s});
		dlt_t  = 7'(dlt) * signed'({5'b00000, t_q});
		num_s  = signed'({2'b00, s_span, 1'b0}) + (dlt_t <<< 1)
			+ signed'({5'b00000, span_q});
		// never below zero for in-range points, clamp for safety
		div_num   = num_s[6] ? '0 : num_s[NUM_W-1:0];
		div_den   = {span_q, 1'b0};
		div_start = (state_q == ST_LINE_NUM);
	end

	vcfb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ------------------------------------------------------------------
	// store write port
	// ------------------------------------------------------------------
	logic [COORD_W-1:0] pt_x, pt_y, pt_z, dom_t;

	always_comb begin
		dom_t = dom_q + t_q;
		case (axis_q)
			AX_X: begin
				pt_x = dom_t;
				pt_y = ca_q;
				pt_z = cb_q;
			end
			AX_Y: begin
				pt_x = ca_q;
				pt_y = dom_t;
				pt_z = cb_q;
			end
			default: begin
				pt_x = ca_q;
				pt_y = cb_q;
				pt_z = dom_t;
			end
		endcase

		wr = '{en: 1'b0, mode: WR_BIT, layer: '0, bit_idx: '0, val: 1'b0};
		if (in_acc) begin
			wr.val = pixel_value;
			case (op)
				OP_SET_XYZ: begin
					wr.en      = 1'b1;
					wr.layer   = start_z;
					wr.bit_idx = {start_y, start_x};
				end
				OP_SET_INDEX: begin
					wr.en      = 1'b1;
					wr.layer   = layer_sel;
					wr.bit_idx = bit_index;
				end
				OP_FILL_LAYR: begin
					wr.en    = 1'b1;
					wr.mode  = WR_LAYER;
					wr.layer = layer_sel;
				end
				OP_FILL_ALL: begin
					wr.en   = 1'b1;
					wr.mode = WR_ALL;
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_LINE_SETUP && su_span == '0) begin
			// zero span: only the start point
			wr.en      = 1'b1;
			wr.val     = val_q;
			wr.layer   = z0_q;
			wr.bit_idx = {y0_q, x0_q};
		end else if (state_q == ST_LINE_WR) begin
			wr.en      = 1'b1;
			wr.val     = val_q;
			wr.layer   = pt_z;
			wr.bit_idx = {pt_y, pt_x};
		end
	end

	vcfb_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_layer (layer_sel),
		.rd_word  (rd_word)
	);

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	assign out_load = (state_q == ST_RD) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= 1'b0;
			t_q      <= '0;
			rd_cnt_q <= RD_LOW;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && op == OP_DRAW_LINE) begin
						state_q <= ST_LINE_SETUP;
					end else if (in_acc && op == OP_READ_LAYR) begin
						state_q  <= ST_RD;
						rd_cnt_q <= RD_LOW;
					end
				end
				ST_LINE_SETUP: begin
					k_q <= 1'b0;
					t_q <= '0;
					if (su_span == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_LINE_NUM;
					end
				end
				ST_LINE_NUM: begin
					state_q <= ST_LINE_DIV;
				end
				ST_LINE_DIV: begin
					if (div_done) begin
						if (k_q) begin
							state_q <= ST_LINE_WR;
						end else begin
							k_q     <= 1'b1;
							state_q <= ST_LINE_NUM;
						end
					end
				end
				ST_LINE_WR: begin
					k_q <= 1'b0;
					if (t_q == span_q) begin
						state_q <= ST_IDLE;
					end else begin
						t_q     <= t_q + 1'b1;
						state_q <= ST_LINE_NUM;
					end
				end
				ST_RD: begin
					if (out_load) begin
						case (rd_cnt_q)
							RD_LOW:  rd_cnt_q <= RD_HIGH;
							RD_HIGH: rd_cnt_q <= RD_SEL;
							default: begin
								rd_cnt_q <= RD_LOW;
								state_q  <= ST_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x0_q       <= start_x;
			y0_q       <= start_y;
			z0_q       <= start_z;
			x1_q       <= end_x;
			y1_q       <= end_y;
			z1_q       <= end_z;
			val_q      <= pixel_value;
			rd_word_q  <= rd_word;
			rd_layer_q <= layer_sel;
		end
		if (state_q == ST_LINE_SETUP) begin
			axis_q <= su_axis;
			span_q <= su_span;
			dom_q  <= su_dom;
			as_q   <= su_as;
			ae_q   <= su_ae;
			bs_q   <= su_bs;
			be_q   <= su_be;
		end
		if (state_q == ST_LINE_DIV && div_done) begin
			if (k_q) begin
				cb_q <= div_quo;
			end else begin
				ca_q <= div_quo;
			end
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_comb begin
		case (rd_cnt_q)
			RD_LOW:  next_byte = rd_word_q[BYTE_W-1:0];
			RD_HIGH: next_byte = rd_word_q[LAYER_W-1:BYTE_W];
			default: next_byte = BYTE_W'(1) << (3'(rd_layer_q) + 3'(SELECT_SHIFT));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= next_byte;
			last_q     <= (rd_cnt_q == RD_SEL);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`VCFB_ASSERT_IMPLIES(a_div_start_idle, clk, arst_n, div_start, !div_busy)
	`VCFB_ASSERT_IMPLIES(a_div_done_state, clk, arst_n, div_done, state_q == ST_LINE_DIV)
	`VCFB_ASSERT_IMPLIES(a_no_wr_in_rd, clk, arst_n, wr.en, state_q != ST_RD)
	`VCFB_ASSERT_IMPLIES(a_sel_byte, clk, arst_n, out_valid && last_byte,
		$onehot(out_byte) && out_byte[3:0] == 4'd0)

endmodule

// ===== tb/sv/voxel_cube_frame_buffer_tb.sv =====
// self-checking testbench of the voxel cube frame buffer: commands in, readout beats checked
module voxel_cube_frame_buffer_tb import vcfb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// opcodes the block must ignore
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	// a line keeps in_ready low until its last point is written
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		logic [2:0]         opcode;
		logic               value;
		logic [COORD_W-1:0] sx, sy, sz;
		logic [COORD_W-1:0] ex, ey, ez;
		logic [BIT_W-1:0]   bit_idx;
		logic [1:0]         layer;
	} voxel_cmd_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              last;
	} readout_beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         opcode = '0;
	logic               pixel_value = 1'b0;
	logic [COORD_W-1:0] start_x = '0;
	logic [COORD_W-1:0] start_y = '0;
	logic [COORD_W-1:0] start_z = '0;
	logic [COORD_W-1:0] end_x = '0;
	logic [COORD_W-1:0] end_y = '0;
	logic [COORD_W-1:0] end_z = '0;
	logic [BIT_W-1:0]   bit_index = '0;
	logic [1:0]         layer_sel = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [BYTE_W-1:0]  out_byte;
	logic               last_byte;

	// predicted cube contents and the readout beats still owed
	logic [LAYER_W-1:0] cube_layers [AXIS_SIZE];
	readout_beat_t      readout_q [$];

	int  mismatch_count = 0;
	int  commands_sent = 0;
	int  lines_sent = 0;
	int  beats_checked = 0;
	int  burst_left = 0;
	bit  sender_idles = 1'b1;
	logic [7:0] stall_phase = '0;

	voxel_cube_frame_buffer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.pixel_value(pixel_value),
		.start_x    (start_x),
		.start_y    (start_y),
		.start_z    (start_z),
		.end_x      (end_x),
		.end_y      (end_y),
		.end_z      (end_z),
		.bit_index  (bit_index),
		.layer_sel  (layer_sel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void paint_voxel(logic v, logic [1:0] x, logic [1:0] y, logic [1:0] z);
		cube_layers[z][{y, x}] = v;
	endfunction

	// start + round half up of delta*t/span, exact in integers
	function automatic logic [1:0] round_coord(int s, int e, int t, int span);
		int num;
		num = 2 * s * span + 2 * (e - s) * t + span;
		if (num < 0)
			num = 0;
		return 2'(num / (2 * span));
	endfunction

	function automatic void predict_line(voxel_cmd_t c);
		int    p [3];
		int    q [3];
		int    axis_len [3];
		int    pt [3];
		int    span;
		int    tmp;
		axis_t dom;
		p[0] = int'(c.sx); p[1] = int'(c.sy); p[2] = int'(c.sz);
		q[0] = int'(c.ex); q[1] = int'(c.ey); q[2] = int'(c.ez);
		for (int k = 0; k < 3; k++)
			axis_len[k] = (p[k] > q[k]) ? p[k] - q[k] : q[k] - p[k];
		// strict majority picks x or y, a tie for the largest falls to z
		if (axis_len[0] > axis_len[1] && axis_len[0] > axis_len[2])
			dom = AX_X;
		else if (axis_len[1] > axis_len[0] && axis_len[1] > axis_len[2])
			dom = AX_Y;
		else
			dom = AX_Z;
		// walk with the dominant coordinate rising
		if (p[int'(dom)] > q[int'(dom)]) begin
			for (int k = 0; k < 3; k++) begin
				tmp = p[k]; p[k] = q[k]; q[k] = tmp;
			end
		end
		span = axis_len[int'(dom)];
		if (span == 0) begin
			paint_voxel(c.value, 2'(p[0]), 2'(p[1]), 2'(p[2]));
			return;
		end
		for (int t = 0; t <= span; t++) begin
			for (int k = 0; k < 3; k++)
				pt[k] = (k == int'(dom)) ? p[k] + t
					: int'(round_coord(p[k], q[k], t, span));
			paint_voxel(c.value, 2'(pt[0]), 2'(pt[1]), 2'(pt[2]));
		end
	endfunction

	function automatic void predict_command(voxel_cmd_t c);
		readout_beat_t beat;
		case (c.opcode)
			OP_SET_XYZ:   paint_voxel(c.value, c.sx, c.sy, c.sz);
			OP_SET_INDEX: paint_voxel(c.value, c.bit_idx[1:0], c.bit_idx[3:2], c.layer);
			OP_FILL_LAYR: cube_layers[c.layer] = {LAYER_W{c.value}};
			OP_FILL_ALL: begin
				for (int k = 0; k < AXIS_SIZE; k++)
					cube_layers[k] = {LAYER_W{c.value}};
			end
			OP_DRAW_LINE: predict_line(c);
			OP_READ_LAYR: begin
				beat.last = 1'b0;
				beat.data = cube_layers[c.layer][7:0];
				readout_q = {readout_q, beat};
				beat.data = cube_layers[c.layer][15:8];
				readout_q = {readout_q, beat};
				beat.data = 8'(32'h1 << (c.layer + SELECT_SHIFT));
				beat.last = 1'b1;
				readout_q = {readout_q, beat};
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- command builders

	function automatic voxel_cmd_t random_cmd(logic [2:0] op);
		voxel_cmd_t c;
		c.opcode  = op;
		c.value   = 1'($urandom_range(0, 1));
		c.sx      = 2'($urandom_range(0, 3));
		c.sy      = 2'($urandom_range(0, 3));
		c.sz      = 2'($urandom_range(0, 3));
		c.ex      = 2'($urandom_range(0, 3));
		c.ey      = 2'($urandom_range(0, 3));
		c.ez      = 2'($urandom_range(0, 3));
		c.bit_idx = 4'($urandom_range(0, 15));
		c.layer   = 2'($urandom_range(0, 3));
		return c;
	endfunction

	function automatic voxel_cmd_t cmd_xyz(logic v, logic [1:0] x, logic [1:0] y, logic [1:0] z);
		voxel_cmd_t c;
		c = random_cmd(OP_SET_XYZ);
		c.value = v;
		c.sx = x; c.sy = y; c.sz = z;
		return c;
	endfunction

	function automatic voxel_cmd_t cmd_layer(logic [2:0] op, logic v, logic [1:0] layer,
			logic [3:0] bidx);
		voxel_cmd_t c;
		c = random_cmd(op);
		c.value = v;
		c.layer = layer;
		c.bit_idx = bidx;
		return c;
	endfunction

	function automatic voxel_cmd_t cmd_line(logic v, logic [1:0] sx, logic [1:0] sy,
			logic [1:0] sz, logic [1:0] ex, logic [1:0] ey, logic [1:0] ez);
		voxel_cmd_t c;
		c = random_cmd(OP_DRAW_LINE);
		c.value = v;
		c.sx = sx; c.sy = sy; c.sz = sz;
		c.ex = ex; c.ey = ey; c.ez = ez;
		return c;
	endfunction

	// ---------------------------------------------------------------- command side

	// one command beat; the sender runs in bursts with random gaps between them
	task automatic send_command(voxel_cmd_t c);
		int gap;
		if (sender_idles && burst_left == 0) begin
			// mostly short gaps, now and then one long enough to span a whole line
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 6);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 8);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		opcode      <= c.opcode;
		pixel_value <= c.value;
		start_x     <= c.sx;
		start_y     <= c.sy;
		start_z     <= c.sz;
		end_x       <= c.ex;
		end_y       <= c.ey;
		end_z       <= c.ez;
		bit_index   <= c.bit_idx;
		layer_sel   <= c.layer;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_command(c);
		commands_sent++;
		if (c.opcode == OP_DRAW_LINE)
			lines_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// hold the sender until all owed beats are out and a line would be done
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (readout_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- readout side

	// receiver stalls: free running, random, one in four, then long on/off stretches
	always @(negedge clk) begin
		stall_phase <= stall_phase + 8'd1;
		case (stall_phase[7:6])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom_range(0, 1));
			2'd2: out_ready <= (stall_phase[1:0] == 2'd0);
			default: out_ready <= stall_phase[4];
		endcase
	end

	always @(posedge clk) begin
		readout_beat_t exp_beat;
		if (arst_n && out_valid && out_ready) begin
			if (readout_q.size() == 0) begin
				$display("%0t: readout beat with nothing owed, got byte %02h last %0b",
					$time, out_byte, last_byte);
				mismatch_count++;
			end else begin
				exp_beat = readout_q.pop_front();
				beats_checked++;
				if (out_byte !== exp_beat.data) begin
					$display("%0t: out_byte mismatch, expected %02h, actual %02h",
						$time, exp_beat.data, out_byte);
					mismatch_count++;
				end
				if (last_byte !== exp_beat.last) begin
					$display("%0t: last_byte mismatch, expected %0b, actual %0b",
						$time, exp_beat.last, last_byte);
					mismatch_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// single voxel writes at the corners and the extreme bit indexes, back to back
	task automatic test_pixel_writes();
		sender_idles = 1'b0;
		send_command(cmd_xyz(1'b1, 2'd3, 2'd3, 2'd3));
		send_command(cmd_xyz(1'b1, 2'd0, 2'd0, 2'd0));
		send_command(cmd_layer(OP_SET_INDEX, 1'b1, 2'd1, 4'd15));
		send_command(cmd_layer(OP_SET_INDEX, 1'b1, 2'd2, 4'd0));
		send_command(cmd_xyz(1'b0, 2'd3, 2'd3, 2'd3));
		send_command(cmd_layer(OP_READ_LAYR, 1'b0, 2'd0, 4'd0));
		send_command(cmd_layer(OP_READ_LAYR, 1'b0, 2'd3, 4'd0));
		sender_idles = 1'b1;
	endtask

	// whole layer and whole cube fills with both values
	task automatic test_fills();
		send_command(cmd_layer(OP_FILL_ALL, 1'b1, 2'd0, 4'd0));
		send_command(cmd_layer(OP_SET_INDEX, 1'b0, 2'd3, 4'd5));
		send_command(cmd_layer(OP_READ_LAYR, 1'b0, 2'd3, 4'd0));
		send_command(cmd_layer(OP_FILL_LAYR, 1'b0, 2'd3, 4'd0));
		send_command(cmd_layer(OP_READ_LAYR, 1'b0, 2'd2, 4'd0));
		send_command(cmd_layer(OP_FILL_ALL, 1'b0, 2'd0, 4'd0));
		send_command(cmd_layer(OP_FILL_LAYR, 1'b1, 2'd1, 4'd0));
		send_command(cmd_layer(OP_READ_LAYR, 1'b0, 2'd1, 4'd0));
	endtask

	// each dominant axis, reversed endpoints, the z tie break and a single point
	task automatic test_lines();
		send_command(cmd_layer(OP_FILL_ALL, 1'b0, 2'd0, 4'd0));
		send_command(cmd_line(1'b1, 2'd0, 2'd0, 2'd0, 2'd3, 2'd3, 2'd3));
		send_command(cmd_line(1'b1, 2'd3, 2'd1, 2'd0, 2'd0, 2'd2, 2'd1));
		send_command(cmd_line(1'b1, 2'd1, 2'd3, 2'd2, 2'd2, 2'd0, 2'd3));
		send_command(cmd_line(1'b1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2));
		send_command(cmd_layer(OP_READ_LAYR, 1'b0, 2'd0, 4'd0));
		send_command(cmd_layer(OP_READ_LAYR, 1'b0, 2'd2, 4'd0));
		send_command(cmd_line(1'b0, 2'd3, 2'd3, 2'd3, 2'd0, 2'd0, 2'd0));
		send_command(cmd_layer(OP_READ_LAYR, 1'b0, 2'd1, 4'd0));
	endtask

	// codes 6 and 7 must leave the cube alone and return nothing
	task automatic test_unused_codes();
		send_command(random_cmd(OP_RSVD_6));
		send_command(random_cmd(OP_RSVD_7));
		send_command(cmd_layer(OP_READ_LAYR, 1'b0, 2'd3, 4'd0));
	endtask

	task automatic test_random_traffic(int n_items);
		int         sent;
		int         pick;
		bit         drained;
		voxel_cmd_t c;
		sent = 0;
		drained = 1'b0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				send_command(random_cmd(OP_READ_LAYR));
				sent++;
			end else if (pick < 42) begin
				c = random_cmd(OP_DRAW_LINE);
				c.value = ($urandom_range(0, 2) != 0);
				send_command(c);
				sent++;
			end else if (pick < 56) begin
				c = random_cmd(OP_SET_XYZ);
				c.value = ($urandom_range(0, 2) != 0);
				send_command(c);
				sent++;
			end else if (pick < 70) begin
				c = random_cmd(OP_SET_INDEX);
				c.value = ($urandom_range(0, 2) != 0);
				send_command(c);
				sent++;
			end else if (pick < 78) begin
				send_command(random_cmd(OP_FILL_LAYR));
				sent++;
			end else if (pick < 81) begin
				send_command(random_cmd(OP_FILL_ALL));
				sent++;
			end else if (pick < 84) begin
				send_command(random_cmd($urandom_range(0, 1) ? OP_RSVD_7 : OP_RSVD_6));
				sent++;
			end else begin
				// draw a line, then read back the layers at both of its ends
				c = random_cmd(OP_DRAW_LINE);
				c.value = 1'b1;
				send_command(c);
				send_command(cmd_layer(OP_READ_LAYR, 1'b0, c.sz, 4'd0));
				send_command(cmd_layer(OP_READ_LAYR, 1'b0, c.ez, 4'd0));
				sent += 3;
			end
			// one full pause halfway through
			if (!drained && sent >= n_items / 2) begin
				wait_drained();
				drained = 1'b1;
			end
		end
	endtask

	// ---------------------------------------------------------------- run

	initial begin
		for (int k = 0; k < AXIS_SIZE; k++)
			cube_layers[k] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_pixel_writes();
		test_fills();
		test_lines();
		test_unused_codes();
		test_random_traffic(145);

		wait_drained();
		$display("covered %0d commands, %0d of them lines, all six commands and both unused codes",
			commands_sent, lines_sent);
		$display("checked %0d readout beats under varying sender gaps and receiver stalls",
			beats_checked);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d readout beats still owed", readout_q.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
